// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL; complex_number_alu_core.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked against clk and rst_n of the including module.
`define CNA_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked against clk and rst_n of the including module.
`define CNA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== sv/cna_pkg.sv =====
package cna_pkg;

  localparam int WORD_BITS  = 16;
  localparam int FRAC_BITS  = 12;
  localparam int ANGLE_FRAC = 30;
  localparam int PROD_BITS  = 2 * WORD_BITS;
  localparam int SUM_BITS   = 2 * WORD_BITS + 1;
  localparam int SAT_BITS   = 2 * WORD_BITS + 2;
  localparam int ANGLE_BITS = 32;

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_ADD  = 3'd0;
  localparam kind_t KIND_SUB  = 3'd1;
  localparam kind_t KIND_MUL  = 3'd2;
  localparam kind_t KIND_DIV  = 3'd3;
  localparam kind_t KIND_CONJ = 3'd4;
  localparam kind_t KIND_MAG  = 3'd5;
  localparam kind_t KIND_ARG  = 3'd6;
  localparam kind_t KIND_EQ   = 3'd7;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam logic signed [ANGLE_BITS-1:0] HALF_PI_Q30 = 32'sd1686629713;

  localparam logic signed [ANGLE_BITS-1:0] ATAN_Q30 [32] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
    32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
    32'sd4194283,   32'sd2097149,   32'sd1048575,   32'sd524288,
    32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
    32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
    32'sd1024,      32'sd512,       32'sd256,       32'sd128,
    32'sd64,        32'sd32,        32'sd16,        32'sd8,
    32'sd4,         32'sd2,         32'sd1,         32'sd0
  };

  typedef struct packed {
    word_t val;
    logic  ov;
  } sat_t;

  typedef struct packed {
    word_t re;
    word_t im;
    logic  ov;
  } part_res_t;

  typedef struct packed {
    part_res_t res;
    logic      dz;
  } div_res_t;

  function automatic sat_t sat_wide(input logic signed [SAT_BITS-1:0] v);
    sat_t r;
    if (v > SAT_BITS'(WORD_MAX)) begin
      r.val = WORD_MAX;
      r.ov  = 1'b1;
    end else if (v < SAT_BITS'(WORD_MIN)) begin
      r.val = WORD_MIN;
      r.ov  = 1'b1;
    end else begin
      r.val = word_t'(v);
      r.ov  = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== sv/cna_in_if.sv =====
interface cna_in_if;
  logic                  valid;
  logic                  ready;
  cna_pkg::kind_t        kind;
  cna_pkg::word_t        a_re;
  cna_pkg::word_t        a_im;
  cna_pkg::word_t        b_re;
  cna_pkg::word_t        b_im;

  modport source (output valid, output kind, output a_re, output a_im,
                  output b_re, output b_im, input ready);
  modport sink (input valid, input kind, input a_re, input a_im,
                input b_re, input b_im, output ready);
endinterface

// ===== sv/cna_out_if.sv =====
interface cna_out_if;
  logic           valid;
  logic           ready;
  cna_pkg::word_t res_re;
  cna_pkg::word_t res_im;
  logic           is_equal;
  logic           div_zero;
  logic           overflow;

  modport source (output valid, output res_re, output res_im, output is_equal,
                  output div_zero, output overflow, input ready);
  modport sink (input valid, input res_re, input res_im, input is_equal,
                input div_zero, input overflow, output ready);
endinterface

// ===== sv/cna_delay.sv =====
module cna_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  generate
    if (DEPTH == 0) begin : g_none
      assign dout = din;
    end else begin : g_line
      logic [WIDTH-1:0] tap_r [DEPTH];

      always_ff @(posedge clk) begin
        if (en) begin
          tap_r[0] <= din;
          for (int i = 1; i < DEPTH; i++) begin
            tap_r[i] <= tap_r[i-1];
          end
        end
      end

      assign dout = tap_r[DEPTH-1];
    end
  endgenerate

endmodule

// ===== sv/cna_div.sv =====
module cna_div (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [cna_pkg::SUM_BITS-1:0]   num_re,
  input  logic signed [cna_pkg::SUM_BITS-1:0]   num_im,
  input  logic        [cna_pkg::PROD_BITS-1:0]  den,
  output cna_pkg::div_res_t                     res
);

  localparam int WB = cna_pkg::WORD_BITS;
  localparam int PB = cna_pkg::PROD_BITS;
  localparam int SW = cna_pkg::SUM_BITS;
  localparam int RW = PB + WB;
  localparam int NS = WB + 1;

  logic          [RW-1:0] rem_r [NS][2];
  logic          [WB-1:0] q_r   [NS][2];
  logic                   neg_r [NS][2];
  logic                   sat_r [NS][2];
  logic          [PB-1:0] den_r [NS];
  logic                   dz_r  [NS];

  logic signed   [SW-1:0] num   [2];
  logic                   neg0  [2];
  logic          [RW-1:0] dvd0  [2];
  logic                   sat0  [2];
  cna_pkg::sat_t          part  [2];

  always_comb begin
    logic signed [SW-1:0] mag;
    num[0] = num_re;
    num[1] = num_im;
    for (int p = 0; p < 2; p++) begin
      neg0[p] = num[p][SW-1];
      mag     = neg0[p] ? -num[p] : num[p];
      dvd0[p] = RW'(mag[PB-1:0]) << cna_pkg::FRAC_BITS;
      sat0[p] = dvd0[p] >= (RW'(den) << WB);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den;
      dz_r[0]  <= (den == '0);
      for (int p = 0; p < 2; p++) begin
        rem_r[0][p] <= dvd0[p];
        q_r[0][p]   <= '0;
        neg_r[0][p] <= neg0[p];
        sat_r[0][p] <= sat0[p];
      end
      for (int s = 1; s < NS; s++) begin
        den_r[s] <= den_r[s-1];
        dz_r[s]  <= dz_r[s-1];
        for (int p = 0; p < 2; p++) begin
          neg_r[s][p] <= neg_r[s-1][p];
          sat_r[s][p] <= sat_r[s-1][p];
          if (rem_r[s-1][p] >= (RW'(den_r[s-1]) << (WB - s))) begin
            rem_r[s][p] <= rem_r[s-1][p] - (RW'(den_r[s-1]) << (WB - s));
            q_r[s][p]   <= q_r[s-1][p] | (WB'(1) << (WB - s));
          end else begin
            rem_r[s][p] <= rem_r[s-1][p];
            q_r[s][p]   <= q_r[s-1][p];
          end
        end
      end
    end
  end

  always_comb begin
    logic signed [WB+1:0] sq;
    for (int p = 0; p < 2; p++) begin
      sq = $signed({2'b00, q_r[NS-1][p]});
      if (neg_r[NS-1][p]) begin
        sq = -sq;
      end
      if (sat_r[NS-1][p]) begin
        part[p].val = neg_r[NS-1][p] ? cna_pkg::WORD_MIN : cna_pkg::WORD_MAX;
        part[p].ov  = 1'b1;
      end else begin
        part[p] = cna_pkg::sat_wide(cna_pkg::SAT_BITS'(sq));
      end
    end
  end

  assign res.res.re = part[0].val;
  assign res.res.im = part[1].val;
  assign res.res.ov = part[0].ov | part[1].ov;
  assign res.dz     = dz_r[NS-1];

endmodule

// ===== sv/cna_sqrt.sv =====
module cna_sqrt (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [cna_pkg::PROD_BITS-1:0]        sq,
  output cna_pkg::part_res_t                   res
);

  localparam int WB = cna_pkg::WORD_BITS;
  localparam int TW = 2 * WB + 1;

  logic [TW-1:0] rem_r  [WB];
  logic [WB-1:0] root_r [WB];
  logic [TW-1:0] trial0;
  cna_pkg::sat_t root_sat;

  assign trial0 = TW'(1) << (2 * (WB - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      if (TW'(sq) >= trial0) begin
        rem_r[0]  <= TW'(sq) - trial0;
        root_r[0] <= WB'(1) << (WB - 1);
      end else begin
        rem_r[0]  <= TW'(sq);
        root_r[0] <= '0;
      end
      for (int s = 1; s < WB; s++) begin
        if (rem_r[s-1] >= ((TW'(root_r[s-1]) << (WB - s)) +
                           (TW'(1) << (2 * (WB - 1 - s))))) begin
          rem_r[s]  <= rem_r[s-1] - ((TW'(root_r[s-1]) << (WB - s)) +
                                     (TW'(1) << (2 * (WB - 1 - s))));
          root_r[s] <= root_r[s-1] | (WB'(1) << (WB - 1 - s));
        end else begin
          rem_r[s]  <= rem_r[s-1];
          root_r[s] <= root_r[s-1];
        end
      end
    end
  end

  assign root_sat = cna_pkg::sat_wide(cna_pkg::SAT_BITS'($signed({1'b0, root_r[WB-1]})));

  assign res.re = root_sat.val;
  assign res.im = '0;
  assign res.ov = root_sat.ov;

endmodule

// ===== sv/cna_cordic.sv =====
module cna_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  cna_pkg::word_t     a_re,
  input  cna_pkg::word_t     a_im,
  output cna_pkg::part_res_t res
);

  localparam int XW = cna_pkg::WORD_BITS + 3;
  localparam int ZW = cna_pkg::ANGLE_BITS;
  localparam int ZS = cna_pkg::ANGLE_FRAC - cna_pkg::FRAC_BITS;
  localparam logic signed [ZW-1:0] POS_AXIS = cna_pkg::HALF_PI_Q30 >>> ZS;
  localparam logic signed [ZW-1:0] NEG_AXIS = (-cna_pkg::HALF_PI_Q30) >>> ZS;

  logic signed [XW-1:0] x_r  [STEPS];
  logic signed [XW-1:0] y_r  [STEPS];
  logic signed [ZW-1:0] z_r  [STEPS];
  logic        [2:0]    fl_r [STEPS];

  logic signed [XW-1:0] x_p  [STEPS];
  logic signed [XW-1:0] y_p  [STEPS];
  logic signed [ZW-1:0] z_p  [STEPS];
  logic        [2:0]    fl_p [STEPS];

  logic signed [ZW-1:0] angle;
  cna_pkg::sat_t        angle_sat;

  always_comb begin
    if (a_re < 0) begin
      x_p[0] = -XW'(a_re);
      y_p[0] = -XW'(a_im);
    end else begin
      x_p[0] = XW'(a_re);
      y_p[0] = XW'(a_im);
    end
    z_p[0]  = '0;
    fl_p[0] = {a_re == 0, a_im > 0, a_im < 0};
    for (int s = 1; s < STEPS; s++) begin
      x_p[s]  = x_r[s-1];
      y_p[s]  = y_r[s-1];
      z_p[s]  = z_r[s-1];
      fl_p[s] = fl_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STEPS; s++) begin
        fl_r[s] <= fl_p[s];
        if (y_p[s] >= 0) begin
          x_r[s] <= x_p[s] + (y_p[s] >>> s);
          y_r[s] <= y_p[s] - (x_p[s] >>> s);
          z_r[s] <= z_p[s] + cna_pkg::ATAN_Q30[s];
        end else begin
          x_r[s] <= x_p[s] - (y_p[s] >>> s);
          y_r[s] <= y_p[s] + (x_p[s] >>> s);
          z_r[s] <= z_p[s] - cna_pkg::ATAN_Q30[s];
        end
      end
    end
  end

  always_comb begin
    if (fl_r[STEPS-1][2]) begin
      if (fl_r[STEPS-1][1]) begin
        angle = POS_AXIS;
      end else if (fl_r[STEPS-1][0]) begin
        angle = NEG_AXIS;
      end else begin
        angle = '0;
      end
    end else begin
      angle = z_r[STEPS-1] >>> ZS;
    end
  end

  assign angle_sat = cna_pkg::sat_wide(cna_pkg::SAT_BITS'(angle));

  assign res.re = angle_sat.val;
  assign res.im = '0;
  assign res.ov = angle_sat.ov;

endmodule

// ===== sv/complex_number_alu_core.sv =====
// Fully pipelined complex ALU on Q4.12 operands: add, subtract, multiply, divide,
// conjugate, magnitude, argument (CORDIC) and equality compare. It accepts one
// transaction per cycle unless out_ch stalls, and delivers results in order.
// A result is presented on out_ch from the output register, behind the longest
// operation path: the divider, which takes a setup stage and then resolves
// one quotient bit per stage over 16 stages behind the input, product and sum
// stages, or the CORDIC chain when it has more steps than that. While a result
// waits on out_ch, every stage holds and in_ch.ready is low.
`include "assert_macros.svh"

module complex_number_alu_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  cna_in_if.sink           in_ch,
  cna_out_if.source        out_ch
);

  localparam int WB = cna_pkg::WORD_BITS;
  localparam int PB = cna_pkg::PROD_BITS;
  localparam int SW = cna_pkg::SUM_BITS;
  localparam int SB = cna_pkg::SAT_BITS;
  localparam int T  = (WB + 3 > CORDIC_STEPS) ? WB + 3 : CORDIC_STEPS;
  localparam int KW = $bits(cna_pkg::kind_t) + 1;

  logic en;
  logic [T:0] vld_r;

  cna_pkg::kind_t kind_a_r;
  cna_pkg::word_t ar_a_r, ai_a_r, br_a_r, bi_a_r;

  logic signed [PB-1:0] p_rr_b_r, p_ii_b_r, p_ri_b_r, p_ir_b_r;
  logic signed [PB-1:0] p_bbr_b_r, p_bbi_b_r, p_aar_b_r, p_aai_b_r;

  logic signed [SW-1:0] mul_re_c_r, mul_im_c_r, num_re_c_r, num_im_c_r;
  logic        [PB-1:0] den_c_r, sq_c_r;

  cna_pkg::sat_t      add_re, add_im, sub_re, sub_im, cnj_im, mul_re, mul_im;
  cna_pkg::part_res_t simple, mul_res, sqrt_res, arg_res;
  cna_pkg::div_res_t  div_res;
  cna_pkg::part_res_t simple_d, mul_d, sqrt_d, arg_d;
  cna_pkg::div_res_t  div_d;
  logic [KW-1:0]      ke_d;
  cna_pkg::kind_t     kind_d;

  logic           out_valid_r;
  cna_pkg::word_t out_re_r, out_re_nxt, out_im_r, out_im_nxt;
  logic           out_eq_r, out_eq_nxt, out_dz_r, out_dz_nxt, out_ov_r, out_ov_nxt;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[T-1:0], in_ch.valid};
      out_valid_r <= vld_r[T];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_a_r <= in_ch.kind;
      ar_a_r   <= in_ch.a_re;
      ai_a_r   <= in_ch.a_im;
      br_a_r   <= in_ch.b_re;
      bi_a_r   <= in_ch.b_im;

      p_rr_b_r  <= ar_a_r * br_a_r;
      p_ii_b_r  <= ai_a_r * bi_a_r;
      p_ri_b_r  <= ar_a_r * bi_a_r;
      p_ir_b_r  <= ai_a_r * br_a_r;
      p_bbr_b_r <= br_a_r * br_a_r;
      p_bbi_b_r <= bi_a_r * bi_a_r;
      p_aar_b_r <= ar_a_r * ar_a_r;
      p_aai_b_r <= ai_a_r * ai_a_r;

      mul_re_c_r <= (SW'(p_rr_b_r) - SW'(p_ii_b_r)) >>> cna_pkg::FRAC_BITS;
      mul_im_c_r <= (SW'(p_ri_b_r) + SW'(p_ir_b_r)) >>> cna_pkg::FRAC_BITS;
      num_re_c_r <= SW'(p_rr_b_r) + SW'(p_ii_b_r);
      num_im_c_r <= SW'(p_ir_b_r) - SW'(p_ri_b_r);
      den_c_r    <= $unsigned(p_bbr_b_r) + $unsigned(p_bbi_b_r);
      sq_c_r     <= $unsigned(p_aar_b_r) + $unsigned(p_aai_b_r);
    end
  end

  always_comb begin
    add_re = cna_pkg::sat_wide(SB'(ar_a_r) + SB'(br_a_r));
    add_im = cna_pkg::sat_wide(SB'(ai_a_r) + SB'(bi_a_r));
    sub_re = cna_pkg::sat_wide(SB'(ar_a_r) - SB'(br_a_r));
    sub_im = cna_pkg::sat_wide(SB'(ai_a_r) - SB'(bi_a_r));
    cnj_im = cna_pkg::sat_wide(-SB'(ai_a_r));
    case (kind_a_r)
      cna_pkg::KIND_ADD: begin
        simple = '{re: add_re.val, im: add_im.val, ov: add_re.ov | add_im.ov};
      end
      cna_pkg::KIND_SUB: begin
        simple = '{re: sub_re.val, im: sub_im.val, ov: sub_re.ov | sub_im.ov};
      end
      cna_pkg::KIND_CONJ: begin
        simple = '{re: ar_a_r, im: cnj_im.val, ov: cnj_im.ov};
      end
      default: begin
        simple = '0;
      end
    endcase
  end

  assign mul_re  = cna_pkg::sat_wide(SB'(mul_re_c_r));
  assign mul_im  = cna_pkg::sat_wide(SB'(mul_im_c_r));
  assign mul_res = '{re: mul_re.val, im: mul_im.val, ov: mul_re.ov | mul_im.ov};

  cna_div u_div (
    .clk    (clk),
    .en     (en),
    .num_re (num_re_c_r),
    .num_im (num_im_c_r),
    .den    (den_c_r),
    .res    (div_res)
  );

  cna_sqrt u_sqrt (
    .clk (clk),
    .en  (en),
    .sq  (sq_c_r),
    .res (sqrt_res)
  );

  cna_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk  (clk),
    .en   (en),
    .a_re (ar_a_r),
    .a_im (ai_a_r),
    .res  (arg_res)
  );

  cna_delay #(.WIDTH($bits(cna_pkg::part_res_t)), .DEPTH(T)) u_dly_simple (
    .clk (clk), .en (en), .din (simple), .dout (simple_d)
  );

  cna_delay #(.WIDTH($bits(cna_pkg::part_res_t)), .DEPTH(T - 2)) u_dly_mul (
    .clk (clk), .en (en), .din (mul_res), .dout (mul_d)
  );

  cna_delay #(.WIDTH($bits(cna_pkg::div_res_t)), .DEPTH(T - WB - 3)) u_dly_div (
    .clk (clk), .en (en), .din (div_res), .dout (div_d)
  );

  cna_delay #(.WIDTH($bits(cna_pkg::part_res_t)), .DEPTH(T - WB - 2)) u_dly_sqrt (
    .clk (clk), .en (en), .din (sqrt_res), .dout (sqrt_d)
  );

  cna_delay #(.WIDTH($bits(cna_pkg::part_res_t)), .DEPTH(T - CORDIC_STEPS)) u_dly_arg (
    .clk (clk), .en (en), .din (arg_res), .dout (arg_d)
  );

  cna_delay #(.WIDTH(KW), .DEPTH(T)) u_dly_kind (
    .clk  (clk),
    .en   (en),
    .din  ({kind_a_r, (ar_a_r == br_a_r) && (ai_a_r == bi_a_r)}),
    .dout (ke_d)
  );

  assign kind_d = ke_d[KW-1:1];

  always_comb begin
    out_re_nxt = '0;
    out_im_nxt = '0;
    out_eq_nxt = 1'b0;
    out_dz_nxt = 1'b0;
    out_ov_nxt = 1'b0;
    case (kind_d)
      cna_pkg::KIND_ADD, cna_pkg::KIND_SUB, cna_pkg::KIND_CONJ: begin
        out_re_nxt = simple_d.re;
        out_im_nxt = simple_d.im;
        out_ov_nxt = simple_d.ov;
      end
      cna_pkg::KIND_MUL: begin
        out_re_nxt = mul_d.re;
        out_im_nxt = mul_d.im;
        out_ov_nxt = mul_d.ov;
      end
      cna_pkg::KIND_DIV: begin
        if (div_d.dz) begin
          out_dz_nxt = 1'b1;
        end else begin
          out_re_nxt = div_d.res.re;
          out_im_nxt = div_d.res.im;
          out_ov_nxt = div_d.res.ov;
        end
      end
      cna_pkg::KIND_MAG: begin
        out_re_nxt = sqrt_d.re;
        out_ov_nxt = sqrt_d.ov;
      end
      cna_pkg::KIND_ARG: begin
        out_re_nxt = arg_d.re;
        out_ov_nxt = arg_d.ov;
      end
      cna_pkg::KIND_EQ: begin
        out_eq_nxt = ke_d[0];
      end
      default: begin
        out_eq_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_re_r <= out_re_nxt;
      out_im_r <= out_im_nxt;
      out_eq_r <= out_eq_nxt;
      out_dz_r <= out_dz_nxt;
      out_ov_r <= out_ov_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.res_re   = out_re_r;
  assign out_ch.res_im   = out_im_r;
  assign out_ch.is_equal = out_eq_r;
  assign out_ch.div_zero = out_dz_r;
  assign out_ch.overflow = out_ov_r;

  `CNA_ASSERT_IMPLIES(a_dz_clean, out_valid_r && out_dz_r,
                      out_re_r == '0 && out_im_r == '0 && !out_ov_r && !out_eq_r)
  `CNA_ASSERT_IMPLIES(a_eq_clean, out_valid_r && out_eq_r,
                      out_re_r == '0 && out_im_r == '0 && !out_ov_r && !out_dz_r)
  `CNA_ASSERT_NEXT(a_tail_moves, en && vld_r[T], out_valid_r)

endmodule
